// ===== hdl/sclc_pkg.sv =====
// Package for the sector cache LRU controller: sizes, codes, payload and
// controller/datapath interface types. Depends on nothing.
package sclc_pkg;

    localparam int ENTRIES  = 64;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int SLOT_W   = 6;
    localparam int SECTOR_W = 32;
    localparam int STAMP_W  = 63;

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [ENTRIES-1:0]  t_mask;
    typedef logic [SECTOR_W-1:0] t_sector;
    typedef logic [STAMP_W-1:0]  t_stamp;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_CLEAN = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ACT_HIT       = 2'd0,
        ACT_FILL      = 2'd1,
        ACT_WRITEBACK = 2'd2,
        ACT_NONE      = 2'd3
    } t_action;

    // Kind of result the datapath is told to build.
    typedef enum logic [2:0] {
        EM_HIT,
        EM_FILL,
        EM_WB_VICTIM,
        EM_WB_FLUSH,
        EM_NONE
    } t_emit;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LK_SCAN,
        ST_LK_DRAIN,
        ST_LK_DECIDE,
        ST_LK_HIT,
        ST_LK_VREAD,
        ST_LK_WB,
        ST_LK_FILL,
        ST_FL_CHK,
        ST_FL_EMIT,
        ST_FL_NONE
    } t_state;

    typedef struct packed {
        t_opcode opcode;
        t_sector sector_number;
        t_stamp  now_tick;
    } t_in;

    typedef struct packed {
        t_action           action;
        logic [SLOT_W-1:0] slot_index;
        t_sector           target_sector;
        logic              last_of_run;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  scan;
        logic  idx_inc;
        logic  idx_sel;
        logic  emit_en;
        t_emit emit_kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic new_lookup;
        logic hit;
        logic at_end;
        logic vd_cur;
        logic more;
    } t_stat;

endpackage

// ===== hdl/sclc_ctrl.sv =====
// Controller state machine of the sector cache LRU controller.
// Depends on sclc_pkg; drives sclc_datapath through t_cmd and reads t_stat.
module sclc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sclc_pkg::t_stat i_stat,
    output sclc_pkg::t_cmd  o_cmd
);
    import sclc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_cmd.load        = 1'b0;
        o_cmd.scan        = 1'b0;
        o_cmd.idx_inc     = 1'b0;
        o_cmd.idx_sel     = 1'b0;
        o_cmd.emit_en     = 1'b0;
        o_cmd.emit_kind   = EM_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.new_lookup ? ST_LK_SCAN : ST_FL_CHK;
                end
            end
            // Walk every entry; the datapath evaluates each entry in the cycle after its index.
            ST_LK_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.at_end) begin
                    n_state = ST_LK_DRAIN;
                end
            end
            ST_LK_DRAIN: begin
                n_state = ST_LK_DECIDE;
            end
            ST_LK_DECIDE: begin
                o_cmd.idx_sel = 1'b1;
                n_state       = i_stat.hit ? ST_LK_HIT : ST_LK_VREAD;
            end
            ST_LK_HIT: begin
                o_cmd.emit_kind = EM_HIT;
                if (i_stat.out_free) begin
                    o_cmd.emit_en = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            // Victim tag is read from memory during this cycle.
            ST_LK_VREAD: begin
                n_state = ST_LK_WB;
            end
            ST_LK_WB: begin
                o_cmd.emit_kind = EM_WB_VICTIM;
                if (!i_stat.vd_cur) begin
                    n_state = ST_LK_FILL;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_en = 1'b1;
                    n_state       = ST_LK_FILL;
                end
            end
            ST_LK_FILL: begin
                o_cmd.emit_kind = EM_FILL;
                if (i_stat.out_free) begin
                    o_cmd.emit_en = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            // Flush or clean: look for the next dirty entry.
            ST_FL_CHK: begin
                if (i_stat.vd_cur) begin
                    n_state = ST_FL_EMIT;
                end else if (i_stat.at_end) begin
                    n_state = ST_FL_NONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_FL_EMIT: begin
                o_cmd.emit_kind = EM_WB_FLUSH;
                if (i_stat.out_free) begin
                    o_cmd.emit_en = 1'b1;
                    if (i_stat.more) begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_FL_CHK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FL_NONE: begin
                o_cmd.emit_kind = EM_NONE;
                if (i_stat.out_free) begin
                    o_cmd.emit_en = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A request taken in idle always moves the controller out of idle.
    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != ST_IDLE))
        else $error("accepted request did not start work");

    // A result is only built when the output register can take it.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_en |-> i_stat.out_free)
        else $error("result emitted while output register busy");

endmodule

// ===== hdl/sclc_datapath.sv =====
// Datapath of the sector cache LRU controller: valid/dirty bits, tag and
// stamp memories, scan trackers and the output register. Depends on sclc_pkg.
module sclc_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sclc_pkg::t_in   i_in_data,
    input  sclc_pkg::t_cmd  i_cmd,
    output sclc_pkg::t_stat o_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sclc_pkg::t_out  o_out_data
);
    import sclc_pkg::*;

    // Request registers.
    t_opcode r_op;
    t_sector r_sector;
    t_stamp  r_tick;

    // Entry index and the registered evaluation index that trails it.
    t_idx r_idx;
    t_idx r_eidx;
    logic r_evld;

    // Entry state.
    t_mask   r_valid;
    t_mask   r_dirty;
    t_sector r_tag_mem   [ENTRIES];
    t_stamp  r_stamp_mem [ENTRIES];
    t_sector r_rd_tag;
    t_stamp  r_rd_stamp;

    // Scan trackers.
    logic   r_hit;
    t_idx   r_hit_idx;
    logic   r_free;
    t_idx   r_free_idx;
    logic   r_min_set;
    t_stamp r_min;
    t_idx   r_min_idx;

    // Output register.
    logic r_out_vld;
    t_out r_out;
    t_out n_out;

    logic  e_valid;
    logic  e_hit;
    logic  e_free;
    logic  e_min;
    t_idx  sel_idx;
    t_mask hi_mask;
    logic  is_write;
    logic  out_free;

    // Evaluation of the entry read in the previous cycle.
    assign e_valid = r_valid[r_eidx];
    assign e_hit   = r_evld && e_valid && !r_hit && (r_rd_tag == r_sector);
    assign e_free  = r_evld && !e_valid && !r_free;
    assign e_min   = r_evld && e_valid && (!r_min_set || (r_rd_stamp < r_min));

    // Chosen entry: first hit, else lowest free slot, else oldest stamp.
    always_comb begin
        priority if (r_hit) begin
            sel_idx = r_hit_idx;
        end else if (r_free) begin
            sel_idx = r_free_idx;
        end else begin
            sel_idx = r_min_idx;
        end
    end

    assign hi_mask  = ({ENTRIES{1'b1}} << r_idx) << 1;
    assign is_write = (r_op == OP_WRITE);
    assign out_free = !r_out_vld || i_out_ready;

    // Status to the controller.
    assign o_stat.out_free   = out_free;
    assign o_stat.new_lookup = (i_in_data.opcode == OP_READ) ||
                               (i_in_data.opcode == OP_WRITE);
    assign o_stat.hit        = r_hit;
    assign o_stat.at_end     = (r_idx == t_idx'(ENTRIES - 1));
    assign o_stat.vd_cur     = r_valid[r_idx] && r_dirty[r_idx];
    assign o_stat.more       = |(r_valid & r_dirty & hi_mask);

    // Evaluation valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evld <= 1'b0;
        end else begin
            r_evld <= i_cmd.scan;
        end
    end

    // Request capture, index stepping and scan trackers.
    always_ff @(posedge i_clk) begin
        r_eidx <= r_idx;
        if (i_cmd.load) begin
            r_op      <= i_in_data.opcode;
            r_sector  <= i_in_data.sector_number;
            r_tick    <= i_in_data.now_tick;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_min_set <= 1'b0;
        end else begin
            if (i_cmd.scan || i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.idx_sel) begin
                r_idx <= sel_idx;
            end
            if (e_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_eidx;
            end
            if (e_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_eidx;
            end
            if (e_min) begin
                r_min_set <= 1'b1;
                r_min     <= r_rd_stamp;
                r_min_idx <= r_eidx;
            end
        end
    end

    // Tag and stamp memories: one registered read and one write per cycle.
    always_ff @(posedge i_clk) begin
        r_rd_tag   <= r_tag_mem[r_idx];
        r_rd_stamp <= r_stamp_mem[r_idx];
        if (i_cmd.emit_en && (i_cmd.emit_kind == EM_FILL)) begin
            r_tag_mem[r_idx] <= r_sector;
        end
        if (i_cmd.emit_en &&
            ((i_cmd.emit_kind == EM_FILL) || (i_cmd.emit_kind == EM_HIT))) begin
            r_stamp_mem[r_idx] <= r_tick;
        end
    end

    // Valid and dirty bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else if (i_cmd.emit_en) begin
            unique case (i_cmd.emit_kind)
                EM_HIT: begin
                    if (is_write) begin
                        r_dirty[r_idx] <= 1'b1;
                    end
                end
                EM_FILL: begin
                    r_valid[r_idx] <= 1'b1;
                    r_dirty[r_idx] <= is_write;
                end
                EM_WB_FLUSH: begin
                    r_dirty[r_idx] <= 1'b0;
                    if (r_op == OP_FLUSH) begin
                        r_valid[r_idx] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result payload for the commanded kind.
    always_comb begin
        n_out.action        = ACT_NONE;
        n_out.slot_index    = SLOT_W'(r_idx);
        n_out.target_sector = r_sector;
        n_out.last_of_run   = 1'b1;
        unique case (i_cmd.emit_kind)
            EM_HIT: begin
                n_out.action = ACT_HIT;
            end
            EM_FILL: begin
                n_out.action = ACT_FILL;
            end
            EM_WB_VICTIM: begin
                n_out.action        = ACT_WRITEBACK;
                n_out.target_sector = r_rd_tag;
                n_out.last_of_run   = 1'b0;
            end
            EM_WB_FLUSH: begin
                n_out.action        = ACT_WRITEBACK;
                n_out.target_sector = r_rd_tag;
                n_out.last_of_run   = !o_stat.more;
            end
            default: begin
                n_out.action        = ACT_NONE;
                n_out.slot_index    = '0;
                n_out.target_sector = '0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit_en) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // A dirty entry is always a valid one.
    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dirty & ~r_valid) == '0)
        else $error("dirty bit set on an invalid entry");

    // A hit result always refers to a valid entry.
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_en && (i_cmd.emit_kind == EM_HIT)) |-> r_valid[r_idx])
        else $error("hit reported on an invalid entry");

    // A flush or clean write-back leaves the entry clean.
    a_flush_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_en && (i_cmd.emit_kind == EM_WB_FLUSH))
        |=> !r_dirty[$past(r_idx)])
        else $error("entry still dirty after write-back");

endmodule

// ===== hdl/sector_cache_lru_controller.sv =====
// Top level of the sector cache LRU controller: joins sclc_ctrl and
// sclc_datapath. Depends on sclc_pkg.
//
//  Channel   Signals                         Direction  Carries
//  request   i_in_valid/o_in_ready/i_in_data  in         opcode, sector, tick
//  result    o_out_valid/i_out_ready/o_out_data out      action, slot, sector, last
//
// A read or write scans the 64 entries one per cycle; a hit then emits its result,
// a miss reads the victim tag, emits a write-back if the victim is dirty, then the
// fill. A flush or clean walks the entries from index 0, emitting a write-back per
// dirty entry, or one no-op result if none is dirty. A new request can be taken in
// the cycle after the last result is built. Reset clears every valid and dirty bit
// at once. A stalled result holds in the output register and pauses the controller.
module sector_cache_lru_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sclc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sclc_pkg::t_out o_out_data
);
    import sclc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Controller state machine.
    sclc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Entry storage and result datapath.
    sclc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/sv/sector_cache_lru_controller_tb.sv =====
// Self-checking testbench for sector_cache_lru_controller: predicts the hit,
// fill, write-back and no-op results of each request and checks them in order.
// Depends on sclc_pkg and the sector_cache_lru_controller RTL.
module sector_cache_lru_controller_tb;
    import sclc_pkg::*;

    localparam int MAX_WRITEBACKS = 64;
    localparam int STALL_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 150;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    // Requests waiting to be driven and results still to arrive.
    t_in     queued_requests[$];
    t_out    awaited_results[$];
    t_sector issued_sectors[$];

    // Predicted cache contents.
    logic        ent_valid[ENTRIES];
    logic        ent_dirty[ENTRIES];
    t_sector     ent_tag[ENTRIES];
    logic [63:0] ent_stamp[ENTRIES];

    int     sender_idle_pct   = 36;
    int     receiver_idle_pct = 83;
    int     mismatches        = 0;
    int     stall_cycles      = 0;
    int     op_seen[4]        = '{default: 0};
    int     act_seen[4]       = '{default: 0};
    t_stamp tick_now          = 63'd100;

    sector_cache_lru_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // Appends one expected result to the in-order list.
    function automatic void await_result(t_action act, int slot, t_sector sector,
                                         logic last);
        t_out r;
        r.action        = act;
        r.slot_index    = slot[SLOT_W-1:0];
        r.target_sector = sector;
        r.last_of_run   = last;
        awaited_results.push_back(r);
    endfunction

    // Updates the cache image for one accepted request and lists its results.
    function automatic void predict_cache_actions(t_in req);
        int          i;
        int          slot;
        int          written;
        bit          hit;
        logic [63:0] tick;
        t_out        tail;
        tick = {1'b0, req.now_tick};
        if (req.opcode == OP_READ || req.opcode == OP_WRITE) begin
            hit  = 1'b0;
            slot = 0;
            // The lowest valid matching entry is the hit.
            for (i = 0; i < ENTRIES; i++) begin
                if (!hit && ent_valid[i] && ent_tag[i] == req.sector_number) begin
                    slot = i;
                    hit  = 1'b1;
                end
            end
            if (hit) begin
                await_result(ACT_HIT, slot, req.sector_number, 1'b1);
            end else begin
                // Victim: lowest free slot, else lowest index of the oldest stamp.
                slot = -1;
                for (i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && !ent_valid[i]) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    slot = 0;
                    for (i = 1; i < ENTRIES; i++) begin
                        if (ent_stamp[i] < ent_stamp[slot]) begin
                            slot = i;
                        end
                    end
                end
                if (ent_valid[slot] && ent_dirty[slot]) begin
                    await_result(ACT_WRITEBACK, slot, ent_tag[slot], 1'b0);
                end
                ent_valid[slot] = 1'b1;
                ent_dirty[slot] = 1'b0;
                ent_tag[slot]   = req.sector_number;
                await_result(ACT_FILL, slot, req.sector_number, 1'b1);
            end
            ent_stamp[slot] = tick;
            if (req.opcode == OP_WRITE) begin
                ent_dirty[slot] = 1'b1;
            end
        end else begin
            // Flush and clean write back every dirty entry from index 0 up.
            written = 0;
            for (i = 0; i < ENTRIES; i++) begin
                if (written < MAX_WRITEBACKS && ent_valid[i] && ent_dirty[i]) begin
                    await_result(ACT_WRITEBACK, i, ent_tag[i], 1'b0);
                    written++;
                    ent_dirty[i] = 1'b0;
                    if (req.opcode == OP_FLUSH) begin
                        ent_valid[i] = 1'b0;
                    end
                end
            end
            if (written == 0) begin
                await_result(ACT_NONE, 0, '0, 1'b1);
            end else begin
                tail = awaited_results.pop_back();
                tail.last_of_run = 1'b1;
                awaited_results.push_back(tail);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input t_out got, input t_out want);
        string got_text;
        string want_text;
        mismatches++;
        got_text  = $sformatf("act=%0d slot=%0d sector=%h last=%b", got.action,
                              got.slot_index, got.target_sector, got.last_of_run);
        want_text = $sformatf("act=%0d slot=%0d sector=%h last=%b", want.action,
                              want.slot_index, want.target_sector, want.last_of_run);
        $display("%0t: %s: got %s, want %s", $realtime, what, got_text, want_text);
    endtask

    function automatic void queue_request(t_opcode op, t_sector sector, t_stamp tick);
        t_in req;
        req.opcode        = op;
        req.sector_number = sector;
        req.now_tick      = tick;
        queued_requests.push_back(req);
    endfunction

    // Mostly rising ticks, with ties, random jumps and the top value mixed in.
    function automatic t_stamp next_tick();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            tick_now = tick_now + t_stamp'($urandom_range(5, 1));
        end else if (roll >= 95) begin
            return '1;
        end else if (roll >= 85) begin
            return t_stamp'({$urandom, $urandom});
        end
        return tick_now;
    endfunction

    // Reads and writes to fresh or reused sectors, with some flushes and cleans.
    task automatic queue_random_requests(input int count);
        int      k;
        int      roll;
        t_sector sector;
        t_opcode op;
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                queue_request(OP_FLUSH, $urandom, next_tick());
            end else if (roll < 15) begin
                queue_request(OP_CLEAN, $urandom, next_tick());
            end else begin
                op = $urandom_range(1) ? OP_WRITE : OP_READ;
                if (issued_sectors.size() != 0 && $urandom_range(99) < 40) begin
                    sector = issued_sectors[$urandom_range(issued_sectors.size() - 1)];
                end else begin
                    sector = $urandom;
                    issued_sectors.push_back(sector);
                end
                queue_request(op, sector, next_tick());
            end
        end
    endtask

    // Waits until every request has gone in and every result has come out.
    task automatic wait_until_drained();
        while (queued_requests.size() != 0 || i_in_valid
               || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Request driver: holds a pending request until it is taken.
    always @(posedge i_clk) begin
        bit drive_next;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            drive_next = i_in_valid && !o_in_ready;
            if (i_in_valid && o_in_ready) begin
                op_seen[i_in_data.opcode]++;
                predict_cache_actions(i_in_data);
            end
            if (!drive_next && queued_requests.size() != 0
                && $urandom_range(99) >= sender_idle_pct) begin
                i_in_data  <= queued_requests.pop_front();
                drive_next = 1'b1;
            end
            i_in_valid <= drive_next;
        end
    end

    // Result monitor: checks each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                act_seen[o_out_data.action]++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", o_out_data, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_out_data.action != want.action) begin
                        report_mismatch("action", o_out_data, want);
                    end
                    if (o_out_data.slot_index != want.slot_index) begin
                        report_mismatch("slot_index", o_out_data, want);
                    end
                    if (o_out_data.target_sector != want.target_sector) begin
                        report_mismatch("target_sector", o_out_data, want);
                    end
                    if (o_out_data.last_of_run != want.last_of_run) begin
                        report_mismatch("last_of_run", o_out_data, want);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int k;
        for (k = 0; k < ENTRIES; k++) begin
            ent_valid[k] = 1'b0;
            ent_dirty[k] = 1'b0;
            ent_tag[k]   = '0;
            ent_stamp[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty flush and clean, field extremes, hits, clean then flush,
        // refill of a freed slot and an equal tick.
        queue_request(OP_FLUSH, '0, '0);
        queue_request(OP_CLEAN, '1, '1);
        queue_request(OP_READ, 32'h0000_0000, 63'd0);
        queue_request(OP_WRITE, 32'hFFFF_FFFF, '1);
        queue_request(OP_READ, 32'hFFFF_FFFF, 63'd5);
        queue_request(OP_WRITE, 32'h0000_0000, 63'd6);
        queue_request(OP_READ, 32'hA5A5_A5A5, 63'd7);
        queue_request(OP_WRITE, 32'h5A5A_5A5A, 63'h2AAA_AAAA_AAAA_AAAA);
        queue_request(OP_CLEAN, 32'h1234_5678, 63'd8);
        queue_request(OP_WRITE, 32'h5A5A_5A5A, 63'h5555_5555_5555_5555);
        queue_request(OP_FLUSH, 32'h8765_4321, 63'd9);
        queue_request(OP_READ, 32'h5A5A_5A5A, 63'd9);
        queue_request(OP_READ, 32'h0000_0000, 63'd9);
        queue_random_requests(10);
        wait_until_drained();

        sender_idle_pct   = 83;
        receiver_idle_pct = 36;
        queue_random_requests(10);
        wait_until_drained();

        // No idling: random traffic, then fill every entry with the top tick so
        // that evictions see all stamps equal, then flush a full cache.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        queue_random_requests(5);
        for (k = 0; k < ENTRIES + 6; k++) begin
            queue_request(OP_WRITE, $urandom, '1);
        end
        queue_request(OP_FLUSH, $urandom, next_tick());
        queue_request(OP_CLEAN, $urandom, next_tick());
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Requests: %0d reads, %0d writes, %0d flushes, %0d cleans.",
                 op_seen[OP_READ], op_seen[OP_WRITE], op_seen[OP_FLUSH], op_seen[OP_CLEAN]);
        $display("Results: %0d hits, %0d fills, %0d write-backs, %0d no-ops; %0d mismatches.",
                 act_seen[ACT_HIT], act_seen[ACT_FILL], act_seen[ACT_WRITEBACK],
                 act_seen[ACT_NONE], mismatches);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
